[sv/gdd_pkg.sv]
// ----------------------------------------------------------------------------
// gdd_pkg
// Shared types, widths and calendar helpers for the day distance block.
// ----------------------------------------------------------------------------
package gdd_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int DIST_W  = 22;
  localparam int DOY_W   = 9;   // day of year, up to 458 for odd month codes
  localparam int CYC_W   = 9;   // year position inside the 400-year cycle

  localparam logic [CYC_W-1:0] MOD_CYCLE = 9'd400;
  localparam logic [DOY_W-1:0] YEAR_DAYS = 9'd365;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_FIRST,
    S_YEARS
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t           op;
    logic [DIST_W-1:0] a;
    logic [DIST_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [DIST_W-1:0] result;
    logic              borrow;
  } alu_rsp_t;

  // Days in all months before month m. Codes above twelve keep summing the
  // extended length table.
  function automatic logic [DOY_W-1:0] cum_days(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] c;
    unique case (m)
      4'd0:    c = 9'd0;
      4'd1:    c = 9'd0;
      4'd2:    c = 9'd31;
      4'd3:    c = 9'd59;
      4'd4:    c = 9'd90;
      4'd5:    c = 9'd120;
      4'd6:    c = 9'd151;
      4'd7:    c = 9'd181;
      4'd8:    c = 9'd212;
      4'd9:    c = 9'd242;
      4'd10:   c = 9'd273;
      4'd11:   c = 9'd304;
      4'd12:   c = 9'd334;
      4'd13:   c = 9'd365;
      4'd14:   c = 9'd395;
      default: c = 9'd426;
    endcase
    return c;
  endfunction

  // Leap test from the year's position in the 400-year cycle.
  function automatic logic is_leap(input logic [CYC_W-1:0] r);
    return (r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
  endfunction

  function automatic logic [DOY_W-1:0] day_of_year(input logic [DAY_W-1:0] d,
                                                   input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DOY_W-1:0] extra;
    extra = (leap && (m >= 4'd3)) ? 9'd1 : 9'd0;
    return cum_days(m) + extra + DOY_W'(d);
  endfunction

  function automatic logic [DOY_W-1:0] year_len(input logic leap);
    return leap ? (YEAR_DAYS + 9'd1) : YEAR_DAYS;
  endfunction

  function automatic logic [CYC_W-1:0] next_cyc(input logic [CYC_W-1:0] r);
    return (r == MOD_CYCLE - 9'd1) ? 9'd0 : (r + 9'd1);
  endfunction

endpackage

[sv/gdd_alu.sv]
// ----------------------------------------------------------------------------
// gdd_alu
// Shared add/subtract unit used for the cycle reduction and the day sums.
// ----------------------------------------------------------------------------
module gdd_alu import gdd_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [DIST_W:0] wide;

  always_comb begin
    unique case (req.op)
      ALU_ADD: wide = {1'b0, req.a} + {1'b0, req.b};
      ALU_SUB: wide = {1'b0, req.a} - {1'b0, req.b};
      default: wide = '0;
    endcase
    rsp.result = wide[DIST_W-1:0];
    rsp.borrow = (req.op == ALU_SUB) && wide[DIST_W];
  end

endmodule

[sv/gdd_ctrl.sv]
// ----------------------------------------------------------------------------
// gdd_ctrl
// Sequencer and datapath registers: orders the dates, reduces the start year
// into the 400-year cycle, then walks the years one per cycle.
// ----------------------------------------------------------------------------
module gdd_ctrl import gdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DAY_W-1:0]   in_first_day,
  input  logic [MONTH_W-1:0] in_first_month,
  input  logic [YEAR_W-1:0]  in_first_year,
  input  logic [DAY_W-1:0]   in_second_day,
  input  logic [MONTH_W-1:0] in_second_month,
  input  logic [YEAR_W-1:0]  in_second_year,
  output alu_req_t           alu_req,
  input  alu_rsp_t           alu_rsp,
  output logic               busy,
  output logic               out_valid,
  output logic [DIST_W-1:0]  out_day_distance
);

  state_t             state_r, state_nxt;
  logic [DAY_W-1:0]   d_lo_r, d_lo_nxt, d_hi_r, d_hi_nxt;
  logic [MONTH_W-1:0] m_lo_r, m_lo_nxt, m_hi_r, m_hi_nxt;
  logic [YEAR_W-1:0]  y_lo_r, y_lo_nxt, y_hi_r, y_hi_nxt;
  logic [YEAR_W-1:0]  rem_r, rem_nxt;
  logic [YEAR_W-1:0]  yr_r, yr_nxt;
  logic [CYC_W-1:0]   cyc_r, cyc_nxt;
  logic [DIST_W-1:0]  acc_r, acc_nxt;
  logic [DIST_W-1:0]  dist_r, dist_nxt;
  logic               valid_r, valid_nxt;

  logic               swap;
  logic               leap;
  logic [DOY_W-1:0]   doy_lo, doy_hi;

  assign swap = {in_first_year, in_first_month, in_first_day} >
                {in_second_year, in_second_month, in_second_day};

  // cyc_r tracks the current year's place in the cycle once S_MOD is done
  assign leap   = is_leap(cyc_r);
  assign doy_lo = day_of_year(d_lo_r, m_lo_r, leap);
  assign doy_hi = day_of_year(d_hi_r, m_hi_r, leap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_lo_r <= d_lo_nxt;
    m_lo_r <= m_lo_nxt;
    y_lo_r <= y_lo_nxt;
    d_hi_r <= d_hi_nxt;
    m_hi_r <= m_hi_nxt;
    y_hi_r <= y_hi_nxt;
    rem_r  <= rem_nxt;
    yr_r   <= yr_nxt;
    cyc_r  <= cyc_nxt;
    acc_r  <= acc_nxt;
    dist_r <= dist_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    d_lo_nxt  = d_lo_r;
    m_lo_nxt  = m_lo_r;
    y_lo_nxt  = y_lo_r;
    d_hi_nxt  = d_hi_r;
    m_hi_nxt  = m_hi_r;
    y_hi_nxt  = y_hi_r;
    rem_nxt   = rem_r;
    yr_nxt    = yr_r;
    cyc_nxt   = cyc_r;
    acc_nxt   = acc_r;
    dist_nxt  = dist_r;
    valid_nxt = 1'b0;
    alu_req   = '{op: ALU_ADD, a: '0, b: '0};

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (swap) begin
            d_lo_nxt = in_second_day;
            m_lo_nxt = in_second_month;
            y_lo_nxt = in_second_year;
            d_hi_nxt = in_first_day;
            m_hi_nxt = in_first_month;
            y_hi_nxt = in_first_year;
            rem_nxt  = in_second_year;
          end else begin
            d_lo_nxt = in_first_day;
            m_lo_nxt = in_first_month;
            y_lo_nxt = in_first_year;
            d_hi_nxt = in_second_day;
            m_hi_nxt = in_second_month;
            y_hi_nxt = in_second_year;
            rem_nxt  = in_first_year;
          end
          state_nxt = S_MOD;
        end
      end

      // start year mod 400 by repeated subtraction
      S_MOD: begin
        alu_req = '{op: ALU_SUB, a: DIST_W'(rem_r), b: DIST_W'(MOD_CYCLE)};
        if (!alu_rsp.borrow) begin
          rem_nxt = alu_rsp.result[YEAR_W-1:0];
        end else begin
          cyc_nxt   = rem_r[CYC_W-1:0];
          state_nxt = S_FIRST;
        end
      end

      S_FIRST: begin
        if (y_lo_r == y_hi_r) begin
          alu_req   = '{op: ALU_SUB, a: DIST_W'(doy_hi), b: DIST_W'(doy_lo)};
          dist_nxt  = alu_rsp.result;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // rest of the start year
          alu_req   = '{op: ALU_SUB, a: DIST_W'(year_len(leap)), b: DIST_W'(doy_lo)};
          acc_nxt   = alu_rsp.result;
          yr_nxt    = y_lo_r + YEAR_W'(1);
          cyc_nxt   = next_cyc(cyc_r);
          state_nxt = S_YEARS;
        end
      end

      S_YEARS: begin
        if (yr_r == y_hi_r) begin
          alu_req   = '{op: ALU_ADD, a: acc_r, b: DIST_W'(doy_hi)};
          dist_nxt  = alu_rsp.result;
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          alu_req = '{op: ALU_ADD, a: acc_r, b: DIST_W'(year_len(leap))};
          acc_nxt = alu_rsp.result;
          yr_nxt  = yr_r + YEAR_W'(1);
          cyc_nxt = next_cyc(cyc_r);
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = valid_r;
  assign out_day_distance = dist_r;

endmodule

[sv/gregorian_day_difference_top.sv]
// ----------------------------------------------------------------------------
// gregorian_day_difference_top
// Absolute number of days between two Gregorian dates.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: two dates (day, month, year) on the in_* ports, taken at the
//   rising edge where start is high and busy is low. busy stays high until
//   the result word is out.
//   Result word: out_day_distance, valid for exactly one cycle while
//   out_valid is high. The receiver cannot stall; it must take the word then.
//   Steps: the start-year reduction mod 400 on the shared add/subtract
//   unit, then, when the years differ, the year walk, one year per cycle
//   on the same unit.
//   busy falls together with out_valid rising, so a new word can be started
//   in the cycle the result is shown.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//   out_valid; a word in flight is lost.
// ----------------------------------------------------------------------------
module gregorian_day_difference_top import gdd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [DAY_W-1:0]   in_first_day,
  input  logic [MONTH_W-1:0] in_first_month,
  input  logic [YEAR_W-1:0]  in_first_year,
  input  logic [DAY_W-1:0]   in_second_day,
  input  logic [MONTH_W-1:0] in_second_month,
  input  logic [YEAR_W-1:0]  in_second_year,
  output logic               out_valid,
  output logic [DIST_W-1:0]  out_day_distance
);

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  gdd_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  gdd_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_first_day     (in_first_day),
    .in_first_month   (in_first_month),
    .in_first_year    (in_first_year),
    .in_second_day    (in_second_day),
    .in_second_month  (in_second_month),
    .in_second_year   (in_second_year),
    .alu_req          (alu_req),
    .alu_rsp          (alu_rsp),
    .busy             (busy),
    .out_valid        (out_valid),
    .out_day_distance (out_day_distance)
  );

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted word");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (busy ##1 !busy) |-> out_valid)
    else $error("sequence ended without a result");

endmodule

[test/tb_gregorian_day_difference_top.sv]
// ----------------------------------------------------------------------------
// tb_gregorian_day_difference_top
// Self-checking bench for the Gregorian day distance block: directed date
// pairs (equal dates, ordering, leap rules, odd field codes, longest spans)
// and random pairs, each checked against a local calendar predictor.
// ----------------------------------------------------------------------------
module tb_gregorian_day_difference_top;
  import gdd_pkg::*;

  localparam int RANDOM_ITEMS   = 80;
  localparam int WATCHDOG_LIMIT = 100000;  // above the longest word
  localparam int DRAIN_CYCLES   = 50;
  localparam int YEAR_MAX       = (1 << YEAR_W) - 1;

  typedef struct {
    int unsigned       item_no;
    logic [DIST_W-1:0] distance;
  } dist_expect_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [DAY_W-1:0]   in_first_day = '0;
  logic [MONTH_W-1:0] in_first_month = '0;
  logic [YEAR_W-1:0]  in_first_year = '0;
  logic [DAY_W-1:0]   in_second_day = '0;
  logic [MONTH_W-1:0] in_second_month = '0;
  logic [YEAR_W-1:0]  in_second_year = '0;
  logic               out_valid;
  logic [DIST_W-1:0]  out_day_distance;

  dist_expect_t pending_distance[$];
  dist_expect_t oldest;
  int unsigned  sent_count = 0;
  int unsigned  checked_count = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  burst_left = 0;
  int unsigned  widest_span = 0;
  int unsigned  idle_cycles = 0;

  gregorian_day_difference_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_first_day     (in_first_day),
    .in_first_month   (in_first_month),
    .in_first_year    (in_first_year),
    .in_second_day    (in_second_day),
    .in_second_month  (in_second_month),
    .in_second_year   (in_second_year),
    .out_valid        (out_valid),
    .out_day_distance (out_day_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  // Month length table, extended past December; note that August and September
  // have their real lengths swapped, and the block follows it as is.
  function automatic int unsigned month_days(input int unsigned i);
    case (i)
      0:                        return 0;
      2:                        return 28;
      4, 6, 8, 11, 13:          return 30;
      default:                  return 31;
    endcase
  endfunction

  function automatic bit [31:0] year_day(input int unsigned d, input int unsigned m,
                                         input int unsigned y);
    bit [31:0] sum;
    sum = 0;
    for (int unsigned i = 0; i < m && i < 15; i++) begin
      sum += month_days(i);
      if (i == 2 && leap_year(y)) sum += 1;
    end
    return sum + d;
  endfunction

  function automatic logic [DIST_W-1:0] expected_distance(
      input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1, input logic [YEAR_W-1:0] y1,
      input logic [DAY_W-1:0] d2, input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
    int unsigned ld, lm, ly, hd, hm, hy;
    bit [31:0]   lo_doy, hi_doy, total;
    bit          swap;
    swap = (y1 > y2) || (y1 == y2 && (m1 > m2 || (m1 == m2 && d1 > d2)));
    if (swap) begin
      ld = 32'(d2); lm = 32'(m2); ly = 32'(y2); hd = 32'(d1); hm = 32'(m1); hy = 32'(y1);
    end else begin
      ld = 32'(d1); lm = 32'(m1); ly = 32'(y1); hd = 32'(d2); hm = 32'(m2); hy = 32'(y2);
    end
    lo_doy = year_day(ld, lm, ly);
    hi_doy = year_day(hd, hm, hy);
    if (ly == hy) begin
      total = hi_doy - lo_doy;
    end else begin
      // all sums wrap at 32 bits, so out-of-range days still match
      total = (leap_year(ly) ? 32'd366 : 32'd365) - lo_doy;
      for (int unsigned y = ly + 1; y < hy; y++)
        total += leap_year(y) ? 32'd366 : 32'd365;
      total += hi_doy;
    end
    return total[DIST_W-1:0];
  endfunction

  // ---------------------------------------------------------------- driver
  // Entered and left at a rising edge. Holds start across back-to-back words.
  task automatic send_dates(input logic [DAY_W-1:0] d1, input logic [MONTH_W-1:0] m1,
                            input logic [YEAR_W-1:0] y1, input logic [DAY_W-1:0] d2,
                            input logic [MONTH_W-1:0] m2, input logic [YEAR_W-1:0] y2);
    dist_expect_t e;
    int unsigned  span;
    start           <= 1'b1;
    in_first_day    <= d1;
    in_first_month  <= m1;
    in_first_year   <= y1;
    in_second_day   <= d2;
    in_second_month <= m2;
    in_second_year  <= y2;
    @(posedge clk);
    while (busy) @(posedge clk);
    e.item_no  = sent_count;
    e.distance = expected_distance(d1, m1, y1, d2, m2, y2);
    pending_distance.push_back(e);
    sent_count++;
    span = 32'((y1 > y2) ? y1 - y2 : y2 - y1);
    if (span > widest_span)
      widest_span = span;
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 5);
    end else begin
      burst_left--;
    end
  endtask

  // ---------------------------------------------------------------- checker
  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_distance.size() == 0) begin
        report_mismatch($sformatf("result word %0d with nothing pending", out_day_distance));
      end else begin
        oldest = pending_distance.pop_front();
        if (out_day_distance !== oldest.distance)
          report_mismatch($sformatf("word %0d: day_distance %0d, want %0d",
                                    oldest.item_no, out_day_distance, oldest.distance));
        checked_count++;
      end
    end
  end

  // Ends the run when neither side moves for too long.
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((start && !busy) || out_valid)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------- tests
  task automatic test_equal_dates();
    send_dates(5'd1, 4'd1, 14'd1, 5'd1, 4'd1, 14'd1);
    send_dates(5'd31, 4'd15, 14'd16383, 5'd31, 4'd15, 14'd16383);
  endtask

  task automatic test_order_and_leap();
    send_dates(5'd1, 4'd3, 14'd2024, 5'd28, 4'd2, 14'd2024);   // first is later
    send_dates(5'd20, 4'd6, 14'd2023, 5'd5, 4'd6, 14'd2023);   // differs by day only
    send_dates(5'd28, 4'd2, 14'd1900, 5'd1, 4'd3, 14'd1900);   // century, not leap
    send_dates(5'd28, 4'd2, 14'd2000, 5'd1, 4'd3, 14'd2000);   // 400 rule, leap
    send_dates(5'd1, 4'd1, 14'd2000, 5'd31, 4'd12, 14'd1999);
    send_dates(5'd1, 4'd1, 14'd1999, 5'd1, 4'd1, 14'd2001);
    send_dates(5'd1, 4'd1, 14'd1899, 5'd1, 4'd1, 14'd1901);
    send_dates(5'd15, 4'd8, 14'd2004, 5'd15, 4'd8, 14'd2003);
  endtask

  task automatic test_odd_fields();
    send_dates(5'd31, 4'd0, 14'd2021, 5'd1, 4'd1, 14'd2021);   // negative, wraps
    send_dates(5'd0, 4'd13, 14'd2024, 5'd31, 4'd2, 14'd2024);
    send_dates(5'd31, 4'd14, 14'd1996, 5'd0, 4'd15, 14'd1996);
    send_dates(5'd31, 4'd15, 14'd2020, 5'd1, 4'd1, 14'd2021);  // day of year past year end
    send_dates(5'd0, 4'd0, 14'd0, 5'd1, 4'd1, 14'd1);           // year zero is leap
    send_dates(5'd1, 4'd3, 14'd0, 5'd1, 4'd3, 14'd400);
    send_dates(5'd31, 4'd2, 14'd2023, 5'd31, 4'd9, 14'd2023);
  endtask

  task automatic test_long_spans();
    send_dates(5'd1, 4'd1, 14'd1, 5'd31, 4'd12, 14'd9999);
    send_dates(5'd31, 4'd12, 14'd9999, 5'd1, 4'd1, 14'd1);
    send_dates(5'd0, 4'd0, 14'd0, 5'd31, 4'd15, 14'd16383);
  endtask

  task automatic pick_date(input bit noisy, input int unsigned y,
                           output logic [DAY_W-1:0] d, output logic [MONTH_W-1:0] m);
    if (noisy) begin
      m = MONTH_W'($urandom_range(0, 15));
      d = DAY_W'($urandom_range(0, 31));
    end else begin
      m = MONTH_W'($urandom_range(1, 12));
      d = DAY_W'($urandom_range(1, month_days(32'(m)) +
                                   ((m == 2 && leap_year(y)) ? 1 : 0)));
    end
  endtask

  // Mostly short year spans keep the year walk cheap; a few go wide.
  task automatic test_random_dates();
    int unsigned      roll, span, y1, y2;
    logic [DAY_W-1:0]   d1, d2;
    logic [MONTH_W-1:0] m1, m2;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      roll = $urandom_range(0, 99);
      y1   = $urandom_range(0, YEAR_MAX);
      if (roll < 60)      span = $urandom_range(0, 2);
      else if (roll < 85) span = $urandom_range(0, 60);
      else if (roll < 96) span = $urandom_range(0, 800);
      else                span = $urandom_range(0, YEAR_MAX);
      if ($urandom_range(0, 1)) y2 = (y1 + span > YEAR_MAX) ? YEAR_MAX : y1 + span;
      else                      y2 = (span > y1) ? 0 : y1 - span;
      pick_date(roll % 10 == 0, y1, d1, m1);
      pick_date(roll % 10 == 1, y2, d2, m2);
      if (roll % 17 == 0) begin
        d2 = d1; m2 = m1; y2 = y1;
      end
      send_dates(d1, m1, y1[YEAR_W-1:0], d2, m2, y2[YEAR_W-1:0]);
    end
  endtask

  initial begin
    int unsigned directed_count;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_equal_dates();
    test_order_and_leap();
    test_odd_fields();
    test_long_spans();
    directed_count = sent_count;
    test_random_dates();
    start <= 1'b0;
    while (pending_distance.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d date pairs (%0d directed, %0d random), checked %0d distances",
             sent_count, directed_count, sent_count - directed_count, checked_count);
    $display("Widest year span %0d, mismatches %0d", widest_span, mismatch_count);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[gregorian_day_difference_top.f]
sv/gdd_pkg.sv
sv/gdd_alu.sv
sv/gdd_ctrl.sv
sv/gregorian_day_difference_top.sv
test/tb_gregorian_day_difference_top.sv
